// ===== rtl/nnir_pkg.sv =====
package nnir_pkg;

  // default store geometry
  localparam int DEF_MAX_COLS = 256;
  localparam int DEF_MAX_ROWS = 256;

  // field widths
  localparam int COORD_W = 8;
  localparam int PIXEL_W = 24;
  localparam int CFG_W   = 9;

  // coordinate times source size, 8 x 9 bits
  localparam int PROD_W  = COORD_W + CFG_W;

  // register reset values
  localparam logic [CFG_W-1:0] SRC_SIZE_RST = 9'd256;
  localparam logic [CFG_W-1:0] DST_SIZE_RST = 9'd150;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SRC_COLS = 2'd0,
    REG_SRC_ROWS = 2'd1,
    REG_DST_COLS = 2'd2,
    REG_DST_ROWS = 2'd3
  } cfg_reg_t;

endpackage

// ===== rtl/nnir_ram.sv =====
module nnir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/nnir_div.sv =====
module nnir_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nnir_pkg::PROD_W-1:0] dividend,
  input  logic [nnir_pkg::CFG_W-1:0]  divisor,
  output logic                        done,
  output logic [nnir_pkg::PROD_W-1:0] quotient
);

  localparam int DW = nnir_pkg::PROD_W;
  localparam int VW = nnir_pkg::CFG_W;
  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[DW-1]};
    diff     = trial - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/nearest_neighbor_image_resize.sv =====
// A fetch transaction runs through the states S_START, S_DIV, S_ADDR and S_DATA;
// the input is not ready again until its result is loaded into the output register,
// so no new item is taken while a fetch is under way. S_DIV lasts as long as the two
// 17-step restoring dividers run side by side; a write goes to the frame store RAM at once.
// Reset (rst_n low, synchronous) restores the size registers, idles the
// control and empties the output register; the frame store is not cleared.
module nearest_neighbor_image_resize #(
  parameter int MAX_COLS = nnir_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = nnir_pkg::DEF_MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // coord_x[7:0], coord_y[15:8], pixel_in[39:16]
  input  logic [0:0]  in_tuser,   // req_type[0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pixel_out[23:0], source_col[31:24], source_row[39:32]
  // configuration port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LIM_C = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int LIM_R = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int PW    = nnir_pkg::PROD_W;
  localparam int PXW   = nnir_pkg::PIXEL_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_DIV   = 5'b00100,
    S_ADDR  = 5'b01000,
    S_DATA  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [8:0] src_cols_r, src_rows_r, dst_cols_r, dst_rows_r;
  logic [7:0] x_r, x_nxt, y_r, y_nxt;
  logic [7:0] col_r, col_nxt, row_r, row_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [PXW-1:0] out_pix_r;
  logic [7:0] out_col_r, out_row_r;

  logic [7:0]     in_x, in_y;
  logic [PXW-1:0] in_pix;
  logic           in_accept;
  logic           in_range;
  logic           wr_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic           rd_en;
  logic [PXW-1:0] rd_data;
  logic           out_load;

  logic [8:0]    s_col, s_row, n_col, n_row;
  logic          div_start;
  logic [PW-1:0] dvd_col, dvd_row, q_col, q_row;
  logic          done_col, done_row;

  // input fields
  assign in_x      = in_tdata[7:0];
  assign in_y      = in_tdata[15:8];
  assign in_pix    = in_tdata[39:16];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cols_r <= nnir_pkg::SRC_SIZE_RST;
      src_rows_r <= nnir_pkg::SRC_SIZE_RST;
      dst_cols_r <= nnir_pkg::DST_SIZE_RST;
      dst_rows_r <= nnir_pkg::DST_SIZE_RST;
    end else if (cfg_wr_en) begin
      case (nnir_pkg::cfg_reg_t'(cfg_index))
        nnir_pkg::REG_SRC_COLS: src_cols_r <= cfg_wdata;
        nnir_pkg::REG_SRC_ROWS: src_rows_r <= cfg_wdata;
        nnir_pkg::REG_DST_COLS: dst_cols_r <= cfg_wdata;
        nnir_pkg::REG_DST_ROWS: dst_rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective sizes: zero acts as one, source limited to the store
  always_comb begin
    if (src_cols_r == 9'd0) s_col = 9'd1;
    else if (src_cols_r > 9'(LIM_C)) s_col = 9'(LIM_C);
    else s_col = src_cols_r;
    if (src_rows_r == 9'd0) s_row = 9'd1;
    else if (src_rows_r > 9'(LIM_R)) s_row = 9'(LIM_R);
    else s_row = src_rows_r;
    n_col = (dst_cols_r == 9'd0) ? 9'd1 : dst_cols_r;
    n_row = (dst_rows_r == 9'd0) ? 9'd1 : dst_rows_r;
  end

  // clamp a quotient to the last source index
  function automatic logic [7:0] clamp_q(input logic [PW-1:0] q, input logic [8:0] s);
    logic [8:0] smax;
    smax = s - 9'd1;
    if (q > {{(PW-9){1'b0}}, smax}) clamp_q = smax[7:0];
    else clamp_q = q[7:0];
  endfunction

  // write path straight into the store
  assign in_range = ({5'b0, in_x} < 13'(MAX_COLS)) && ({5'b0, in_y} < 13'(MAX_ROWS));
  assign wr_en    = in_accept && !in_tuser[0] && in_range;
  assign wr_addr  = AW'(in_y) * AW'(MAX_COLS) + AW'(in_x);
  assign rd_addr  = AW'(row_r) * AW'(MAX_COLS) + AW'(col_r);
  assign rd_en    = (state_r == S_ADDR);

  // products feed the divider input registers
  assign div_start = (state_r == S_START);
  assign dvd_col   = {9'b0, x_r} * {8'b0, s_col};
  assign dvd_row   = {9'b0, y_r} * {8'b0, s_row};
  assign out_load  = (state_r == S_DATA) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_accept && in_tuser[0]) begin
          x_nxt     = in_x;
          y_nxt     = in_y;
          state_nxt = S_START;
        end
      end
      S_START: state_nxt = S_DIV;
      S_DIV: begin
        if (done_col && done_row) begin
          col_nxt   = clamp_q(q_col, s_col);
          row_nxt   = clamp_q(q_row, s_row);
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: state_nxt = S_DATA;
      S_DATA: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    col_r <= col_nxt;
    row_r <= row_nxt;
    if (out_load) begin
      out_pix_r <= rd_data;
      out_col_r <= col_r;
      out_row_r <= row_r;
    end
  end

  // column and row dividers
  nnir_div u_div_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_col),
    .divisor  (n_col),
    .done     (done_col),
    .quotient (q_col)
  );

  nnir_div u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_row),
    .divisor  (n_row),
    .done     (done_row),
    .quotient (q_row)
  );

  // frame store
  nnir_ram #(
    .WIDTH (PXW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_pix),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_row_r, out_col_r, out_pix_r};

endmodule

// ===== rtl/nnir_checker.sv =====
module nnir_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a fetch keeps the input side closed while it is worked on
  a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !in_tready)
    else $error("input accepted during a fetch");

  // a new result appears only from the busy read stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

endmodule

bind nearest_neighbor_image_resize nnir_checker u_nnir_checker (.*);
